// File: hw/rtl/sincos_pkg.sv
// Package for the sine/cosine minimax polynomial core: formats, constants, rounding.
package sincos_pkg;

  // Default number of fraction bits of the input angle
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;

  // Stage formats
  typedef logic signed [31:0] angle_t;  // input angle, signed Qx.F
  typedef logic signed [35:0] y_t;      // reduced angle, Q.32
  typedef logic signed [30:0] yq_t;     // reduced angle, Q.28
  typedef logic        [30:0] y2_t;     // y squared, Q.28, never negative
  typedef logic signed [34:0] acc_t;    // Horner accumulator, Q.32
  typedef logic signed [63:0] prod_t;   // full product before rounding
  typedef logic signed [32:0] cos_t;    // cosine before clamping, Q.30

  // 1/(2*pi) rounded to Q.32
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  // 2*pi in Q.32 split as integer part and fraction word, plus a tail word (the next 32 fraction bits, held in 28 bits)
  localparam logic [2:0]  TWO_PI_INT  = 3'd6;
  localparam logic [31:0] TWO_PI_FRAC = 32'h487E_D511;
  localparam logic [27:0] TWO_PI_TAIL = 28'hB46_11A6;
  localparam y_t PI_Q32      = 36'sd13493037705;
  localparam y_t HALF_PI_Q32 = 36'sd6746518852;
  localparam prod_t ONE_Q30  = 64'sd1073741824;

  // Minimax coefficients in Q.32, highest degree first
  localparam acc_t SIN_COEF [6] = '{
    -35'sd103, 35'sd11822, -35'sd852159, 35'sd35791384, -35'sd715827897, 35'sd4294967296
  };
  localparam acc_t COS_COEF [6] = '{
    -35'sd1119, 35'sd106346, -35'sd5965013, 35'sd178956848, -35'sd2147483648,
    35'sd4294967296
  };

  // Rounding right shift: magnitude rounded to nearest, halves away from zero
  function automatic prod_t rshr(prod_t v, int unsigned s);
    prod_t half;
    prod_t t;
    half = 64'sd1 <<< (s - 1);
    t    = v + half - $signed({63'd0, v[63]});
    return t >>> s;
  endfunction

  // Clamp to plus or minus one in Q.30
  function automatic logic signed [31:0] sat_one(prod_t v);
    prod_t c;
    if (v > ONE_Q30) begin
      c = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      c = -ONE_Q30;
    end else begin
      c = v;
    end
    return c[31:0];
  endfunction

endpackage

// File: hw/rtl/sincos_minimax_poly_core.sv
// Top level of the pipelined sine/cosine core: range reduction, fold, Horner lanes.

// Sine and cosine of a signed fixed-point angle (radians, ANGLE_FRAC_BITS
// fraction bits), both as signed Q1.30 clamped to plus or minus one. The core
// is a 21-stage pipeline: an item is taken at every edge with start high (busy
// is always low), and its result shows on sine_o/cosine_o, registered, with
// valid_o high for one cycle. The rate is one item per clock; the pipeline
// holds the range-reduction multipliers, the fold and squaring stages, the five
// two-stage Horner steps (multiply, then round and add) and the output stages.
// The receiver cannot stall, so results must be taken when valid_o is high.
module sincos_minimax_poly_core
  import sincos_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  angle_t angle_i,
  output logic   valid_o,
  output logic signed [31:0] sine_o,
  output logic signed [31:0] cosine_o
);

  localparam int unsigned QMW  = 30 - ANGLE_FRAC_BITS;  // quotient width
  localparam int unsigned QRND = 31 + ANGLE_FRAC_BITS;  // quotient rounding bit
  localparam int unsigned XSH  = 32 - ANGLE_FRAC_BITS;  // angle to Q.32 shift
  localparam int unsigned HST  = 10;                     // Horner pipe stages

  // Never stalls
  assign busy = 1'b0;

  // Valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, va_q;
  logic [HST-1:0] pv_q;

  // Payload registers
  angle_t x1_q, x2_q, x3_q, x4_q;
  logic [61:0] qprod_q;
  logic [QMW-1:0] qm2_q, qm3_q;
  logic [QMW+31:0] plo_q;
  logic [QMW+27:0] ptail_q;
  logic [63:0] sub4_q;
  y_t y5_q, y6_q;
  logic cs6_q, cs7_q, cs8_q, cs9_q;
  yq_t yq7_q, yq8_q, yq9_q;
  logic [61:0] sq8_q;
  y2_t y2_9_q;
  yq_t pyq_q [HST];
  logic pcs_q [HST];
  y2_t py2_q [HST-2];
  prod_t sprod_q [5];
  prod_t cprod_q [5];
  acc_t sacc_q [5];
  acc_t cacc_q [5];
  prod_t fs_q;
  cos_t fc_q;

  // Stage combinational values
  logic [31:0] mag;
  logic [61:0] qsum;
  prod_t xs, yfull;
  y_t yfold;
  logic yflip;
  prod_t yq_r, y2_r, sc_r, cs_r;

  always_comb begin
    // stage 1: magnitude of the angle
    mag = angle_i[31] ? 32'(-angle_i) : 32'(angle_i);
    // stage 2: rounded quotient
    qsum = qprod_q + (62'd1 << QRND);
    // stage 5: remainder in Q.32
    xs = 64'(x4_q) <<< XSH;
    yfull = x4_q[31] ? xs + $signed(sub4_q) : xs - $signed(sub4_q);
    // stage 6: fold into [-pi/2, pi/2]
    if (y5_q > HALF_PI_Q32) begin
      yfold = PI_Q32 - y5_q;
      yflip = 1'b1;
    end else if (y5_q < -HALF_PI_Q32) begin
      yfold = -PI_Q32 - y5_q;
      yflip = 1'b1;
    end else begin
      yfold = y5_q;
      yflip = 1'b0;
    end
    // stage 7 and 9: roundings
    yq_r = rshr(64'(y6_q), 4);
    y2_r = rshr($signed({2'b00, sq8_q}), 28);
    // output stages: cosine rounding and sign, sine rounding
    cs_r = rshr(64'(cacc_q[4]), 2);
    if (pcs_q[HST-1]) begin
      cs_r = -cs_r;
    end
    sc_r = rshr(fs_q, 30);
  end

  // Valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q} <= '0;
      pv_q    <= '0;
      va_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= start & ~busy;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      v8_q    <= v7_q;
      v9_q    <= v8_q;
      pv_q    <= {pv_q[HST-2:0], v9_q};
      va_q    <= pv_q[HST-1];
      valid_o <= va_q;
    end
  end

  // Range reduction, fold and squaring payload
  always_ff @(posedge clk_i) begin
    x1_q    <= angle_i;
    qprod_q <= 62'(mag * INV_TWO_PI_Q32);
    x2_q    <= x1_q;
    qm2_q   <= qsum[QRND+1 +: QMW];
    x3_q    <= x2_q;
    qm3_q   <= qm2_q;
    plo_q   <= (QMW+32)'(qm2_q * TWO_PI_FRAC);
    ptail_q <= (QMW+28)'(qm2_q * TWO_PI_TAIL);
    x4_q    <= x3_q;
    sub4_q  <= ((64'(qm3_q) * 64'(TWO_PI_INT)) << 32) + 64'(plo_q)
             + ((64'(ptail_q) + 64'h8000_0000) >> 32);
    y5_q    <= yfull[35:0];
    y6_q    <= yfold;
    cs6_q   <= yflip;
    yq7_q   <= yq_r[30:0];
    cs7_q   <= cs6_q;
    sq8_q   <= 62'(yq7_q * yq7_q);
    yq8_q   <= yq7_q;
    cs8_q   <= cs7_q;
    y2_9_q  <= y2_r[30:0];
    yq9_q   <= yq8_q;
    cs9_q   <= cs8_q;
  end

  // Side lines that travel with the Horner lanes
  always_ff @(posedge clk_i) begin
    pyq_q[0] <= yq9_q;
    pcs_q[0] <= cs9_q;
    py2_q[0] <= y2_9_q;
    for (int j = 1; j < HST; j++) begin
      pyq_q[j] <= pyq_q[j-1];
      pcs_q[j] <= pcs_q[j-1];
    end
    for (int j = 1; j < HST - 2; j++) begin
      py2_q[j] <= py2_q[j-1];
    end
  end

  // Horner steps: multiply stage, then round-and-add stage, sine and cosine lanes
  for (genvar k = 0; k < 5; k++) begin : g_horner
    acc_t s_in, c_in;
    y2_t  y2_in;
    if (k == 0) begin : g_first
      assign s_in  = SIN_COEF[0];
      assign c_in  = COS_COEF[0];
      assign y2_in = y2_9_q;
    end else begin : g_next
      assign s_in  = sacc_q[k-1];
      assign c_in  = cacc_q[k-1];
      assign y2_in = py2_q[2*k-1];
    end

    prod_t s_rnd, c_rnd;
    assign s_rnd = rshr(sprod_q[k], 28);
    assign c_rnd = rshr(cprod_q[k], 28);

    always_ff @(posedge clk_i) begin
      sprod_q[k] <= 64'(s_in * $signed({1'b0, y2_in}));
      cprod_q[k] <= 64'(c_in * $signed({1'b0, y2_in}));
      sacc_q[k]  <= s_rnd[34:0] + SIN_COEF[k+1];
      cacc_q[k]  <= c_rnd[34:0] + COS_COEF[k+1];
    end
  end

  // Output: sine by the odd factor, cosine rounded, both clamped
  always_ff @(posedge clk_i) begin
    fs_q     <= 64'(sacc_q[4] * pyq_q[HST-1]);
    fc_q     <= cs_r[32:0];
    sine_o   <= sat_one(sc_r);
    cosine_o <= sat_one(64'(fc_q));
  end

  // Checks
  a_valid_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 21))
    else $error("result strobe without a matching accepted item");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> (y6_q <= HALF_PI_Q32 && y6_q >= -HALF_PI_Q32))
    else $error("folded angle outside [-pi/2, pi/2]");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (sine_o <= 32'sd1073741824 && sine_o >= -32'sd1073741824
                 && cosine_o <= 32'sd1073741824 && cosine_o >= -32'sd1073741824))
    else $error("result outside plus or minus one");

endmodule

// File: tb/sincos_result_checker.sv
// Checker for the sine/cosine core: predicts each result from accepted angles and compares.
module sincos_result_checker
  import sincos_pkg::*;
#(
  parameter int unsigned FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  angle_t             angle_i,
  input  logic               valid_o,
  input  logic signed [31:0] sine_o,
  input  logic signed [31:0] cosine_o,
  output int                 err_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } trig_pair_t;

  // Reduction constants, Q.32 unless noted
  localparam logic [63:0] RECIP_TWO_PI = 64'd683565276;
  localparam logic [63:0] TWO_PI_HI    = 64'h6_487E_D511;
  localparam logic [63:0] TWO_PI_LO    = 64'h0B46_11A6;
  localparam wide_t       PI_FX        = 64'sd13493037705;
  localparam wide_t       HALF_PI_FX   = 64'sd6746518852;
  localparam wide_t       UNIT_Q30     = 64'sd1073741824;

  // Polynomial coefficients, Q.32, highest degree first
  localparam wide_t SIN_K [6] = '{
    -64'sd103, 64'sd11822, -64'sd852159, 64'sd35791384, -64'sd715827897, 64'sd4294967296
  };
  localparam wide_t COS_K [6] = '{
    -64'sd1119, 64'sd106346, -64'sd5965013, 64'sd178956848, -64'sd2147483648,
    64'sd4294967296
  };

  trig_pair_t sincos_exp_q [$];
  int         n_pushed;
  int         n_popped;
  int         n_errors;

  assign pending_o   = n_pushed - n_popped;
  assign err_count_o = n_errors;
  assign checked_o   = n_popped;

  // Shift right, magnitude rounded to nearest with halves away from zero
  function automatic wide_t round_shift(wide_t v, int unsigned s);
    wide_t half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  function automatic wide_t clamp_unit(wide_t v);
    if (v > UNIT_Q30) begin
      return UNIT_Q30;
    end
    if (v < -UNIT_Q30) begin
      return -UNIT_Q30;
    end
    return v;
  endfunction

  function automatic wide_t horner_eval(wide_t k [6], wide_t y2);
    wide_t acc;
    acc = k[0];
    for (int i = 1; i < 6; i++) begin
      acc = round_shift(acc * y2, 28) + k[i];
    end
    return acc;
  endfunction

  // Expected sine and cosine of one angle
  function automatic trig_pair_t calc_sincos(angle_t ang);
    wide_t       x;
    wide_t       y;
    wide_t       yq;
    wide_t       y2;
    wide_t       s;
    wide_t       c;
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] sub;
    logic        neg;
    logic        flip;
    trig_pair_t  r;
    x    = {{32{ang[31]}}, ang};
    neg  = x < 0;
    mag  = neg ? 64'(-x) : 64'(x);
    quo  = (mag * RECIP_TWO_PI + (64'd1 << (31 + FRAC_BITS))) >> (32 + FRAC_BITS);
    sub  = quo * TWO_PI_HI + ((quo * TWO_PI_LO + 64'h8000_0000) >> 32);
    y    = x <<< (32 - FRAC_BITS);
    y    = neg ? y + $signed(sub) : y - $signed(sub);
    flip = 1'b0;
    // fold into [-pi/2, pi/2]; exactly pi/2 stays as it is
    if (y > HALF_PI_FX) begin
      y    = PI_FX - y;
      flip = 1'b1;
    end else if (y < -HALF_PI_FX) begin
      y    = -PI_FX - y;
      flip = 1'b1;
    end
    yq = round_shift(y, 4);
    y2 = round_shift(yq * yq, 28);
    s  = clamp_unit(round_shift(horner_eval(SIN_K, y2) * yq, 30));
    c  = round_shift(horner_eval(COS_K, y2), 2);
    if (flip) begin
      c = -c;
    end
    c        = clamp_unit(c);
    r.sine   = s[31:0];
    r.cosine = c[31:0];
    return r;
  endfunction

  // Compare results against the oldest expectation, then record the new item
  always @(posedge clk_i or negedge rst_ni) begin
    trig_pair_t want;
    int         errs;
    if (!rst_ni) begin
      sincos_exp_q.delete();
      n_pushed <= 0;
      n_popped <= 0;
      n_errors <= 0;
    end else begin
      errs = 0;
      if (valid_o) begin
        if (sincos_exp_q.size() == 0) begin
          $display("%0t unexpected result: sine %0d cosine %0d", $time, sine_o, cosine_o);
          errs++;
        end else begin
          want = sincos_exp_q.pop_front();
          n_popped <= n_popped + 1;
          if (sine_o !== want.sine) begin
            $display("%0t sine mismatch: expected %0d, got %0d", $time, want.sine, sine_o);
            errs++;
          end
          if (cosine_o !== want.cosine) begin
            $display("%0t cosine mismatch: expected %0d, got %0d",
                     $time, want.cosine, cosine_o);
            errs++;
          end
        end
      end
      n_errors <= n_errors + errs;
      if (start && !busy) begin
        sincos_exp_q.push_back(calc_sincos(angle_i));
        n_pushed <= n_pushed + 1;
      end
    end
  end

endmodule

// File: tb/tb_sincos_minimax_poly_core.sv
// Testbench top for the sine/cosine core: clock, reset, angle stimulus and verdict.
module tb_sincos_minimax_poly_core
  import sincos_pkg::*;
();

  localparam int RAND_PER_PHASE = 150;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int HALF_PI_Q16    = 102944;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  angle_t             angle_i;
  logic               valid_o;
  logic signed [31:0] sine_o;
  logic signed [31:0] cosine_o;
  int                 err_count;
  int                 pending;
  int                 checked;
  int                 idle_pct;
  int                 n_sent;
  int                 stall_cyc;

  sincos_minimax_poly_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .angle_i  (angle_i),
    .valid_o  (valid_o),
    .sine_o   (sine_o),
    .cosine_o (cosine_o)
  );

  sincos_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .angle_i     (angle_i),
    .valid_o     (valid_o),
    .sine_o      (sine_o),
    .cosine_o    (cosine_o),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog: cycles with no item accepted and no result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cyc <= 0;
    end else begin
      if ((start && !busy) || valid_o) begin
        stall_cyc <= 0;
      end else if (stall_cyc >= STALL_LIMIT) begin
        $display("%0t watchdog expired, %0d results outstanding", $time, pending);
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cyc <= stall_cyc + 1;
      end
    end
  end

  // Offer one angle after a random gap, return at the accepting edge
  task automatic send_angle(angle_t a);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    angle_i <= a;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    n_sent++;
  endtask

  // Hold off until every expected result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random angle: full range, a few turns, near quarter turns, or near full scale
  function automatic angle_t pick_angle();
    int k;
    case ($urandom_range(0, 3))
      0: return angle_t'($urandom);
      1: return angle_t'(int'($urandom_range(0, 1647100)) - 823550);
      2: begin
        k = int'($urandom_range(0, 2000)) - 1000;
        return angle_t'(k * HALF_PI_Q16 + int'($urandom_range(0, 64)) - 32);
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return angle_t'(32'h7FFF_FFFF - $urandom_range(0, 4095));
        end
        return angle_t'(32'h8000_0000 + $urandom_range(0, 4095));
      end
    endcase
  endfunction

  initial begin
    angle_t corner_q [$];
    corner_q = '{
      32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
      32'sd102943, 32'sd102944, -32'sd102943, -32'sd102944,
      32'sd205887, 32'sd205888, -32'sd205887, -32'sd205888,
      32'sd411774, 32'sd411775, -32'sd411775, 32'sd617662, -32'sd617662,
      32'sd65536, -32'sd65536, 32'sh4000_0000, 32'shC000_0000, 32'sd16
    };
    rst_ni    = 1'b0;
    start     = 1'b0;
    angle_i   = '0;
    idle_pct  = 0;
    n_sent    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners, back to back
    foreach (corner_q[i]) begin
      send_angle(corner_q[i]);
    end
    drain_results();

    // random: an often idle sender, then a sparse one, then full rate
    idle_pct = 35;
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      if (i == RAND_PER_PHASE / 2) begin
        drain_results();
      end
      send_angle(pick_angle());
    end
    drain_results();
    idle_pct = 73;
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      send_angle(pick_angle());
    end
    drain_results();
    idle_pct = 0;
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      send_angle(pick_angle());
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d angles, compared %0d sine/cosine pairs", n_sent, checked);
    $display("Covered reduction and fold boundaries, full-scale angles, three gap profiles");
    if (err_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
